// File: design/macd_pkg.sv
package macd_pkg;

  localparam int MAX_PERIOD    = 255;
  localparam int FRACTION_BITS = 16;
  localparam int ALPHA_FRAC    = 30;
  localparam int ACC_W         = 48;
  localparam int VAL_W         = 33;
  localparam int DIV_W         = 42;
  localparam int DEN_W         = 9;
  localparam int PROD_W        = 64;

  localparam logic [1:0] REG_FAST   = 2'd0;
  localparam logic [1:0] REG_SLOW   = 2'd1;
  localparam logic [1:0] REG_SIGNAL = 2'd2;

  localparam logic [1:0] EMA_FAST   = 2'd0;
  localparam logic [1:0] EMA_SLOW   = 2'd1;
  localparam logic [1:0] EMA_SIGNAL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SEED,
    ST_ALPHA,
    ST_MUL,
    ST_UPD,
    ST_NEXT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_SEED,
    EV_ALPHA,
    EV_MUL
  } eval_t;

  typedef struct packed {
    logic       latch_in;
    logic [1:0] k;
    logic       eval_commit;
    logic       div_go;
    logic       div_alpha;
    logic       seed_write;
    logic       alpha_write;
    logic       mul_load;
    logic       upd_write;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    eval_t ev;
    logic  div_busy;
    logic  out_free;
  } status_t;

  function automatic logic [7:0] clamp_period(input logic [7:0] p);
    logic [15:0] w;
    w = {8'd0, p};
    if (w > 16'(MAX_PERIOD)) begin
      return 8'(MAX_PERIOD);
    end
    return p;
  endfunction

endpackage

// File: design/macd_in_if.sv
interface macd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] price;
  logic        price_missing;

  modport source (output valid, price, price_missing, input ready);
  modport sink (input valid, price, price_missing, output ready);
endinterface

// File: design/macd_out_if.sv
interface macd_out_if;
  logic               valid;
  logic               ready;
  logic               macd_valid;
  logic signed [32:0] macd_value;
  logic               signal_valid;
  logic signed [32:0] signal_line;
  logic signed [32:0] histogram;
  logic               cross_up;
  logic               cross_down;

  modport source (output valid, macd_valid, macd_value, signal_valid, signal_line,
                  histogram, cross_up, cross_down, input ready);
  modport sink (input valid, macd_valid, macd_value, signal_valid, signal_line,
                histogram, cross_up, cross_down, output ready);
endinterface

// File: design/macd_cfg_if.sv
interface macd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/macd_div.sv
// Restoring divider, one quotient bit per cycle.
module macd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [macd_pkg::DIV_W-1:0]    num,
  input  logic [macd_pkg::DEN_W-1:0]    den,
  output logic                          busy,
  output logic [macd_pkg::DIV_W-1:0]    quo
);

  logic [macd_pkg::DEN_W-1:0] rem;
  logic [macd_pkg::DEN_W-1:0] den_q;
  logic [5:0]                 cnt;
  logic [macd_pkg::DEN_W:0]   trial;
  logic                       take;

  always_comb begin
    trial = {rem, quo[macd_pkg::DIV_W-1]};
    take  = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'(macd_pkg::DIV_W);
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_q <= den;
    end else if (busy) begin
      rem <= take ? macd_pkg::DEN_W'(trial - {1'b0, den_q}) : trial[macd_pkg::DEN_W-1:0];
      quo <= {quo[macd_pkg::DIV_W-2:0], take};
    end
  end

endmodule

// File: design/macd_datapath.sv
module macd_datapath (
  input  logic              clk,
  input  logic              rst,
  input  macd_pkg::cmd_t    cmd,
  output macd_pkg::status_t status,
  input  logic [31:0]       price,
  input  logic              price_missing,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              macd_valid,
  output logic signed [32:0] macd_value,
  output logic              signal_valid,
  output logic signed [32:0] signal_line,
  output logic signed [32:0] histogram,
  output logic              cross_up,
  output logic              cross_down
);

  logic [7:0]                         period [3];
  logic signed [macd_pkg::ACC_W-1:0]  acc    [3];
  logic [7:0]                         cnt    [3];
  logic [31:0]                        alpha  [3];
  logic [2:0]          started, seeded, dead, alpha_ok, vld;
  logic [31:0]         price_q;
  logic                missing_q;
  logic                seed_neg, d_neg;
  logic [macd_pkg::PROD_W-1:0] prod;
  logic signed [32:0]  prev_macd, prev_sig;
  logic                prev_bv;

  logic [7:0]                        pk;
  logic signed [macd_pkg::ACC_W-1:0] acc_k, x, sum, sum_mag, d, d_mag, r;
  logic signed [32:0]   macd;
  logic                 mv, present;
  logic [7:0]           cnt1;
  logic [8:0]           pk1;
  logic [macd_pkg::DIV_W-1:0] div_num, quo;
  logic [macd_pkg::DEN_W-1:0] div_den;
  logic                 div_busy;
  logic                 gv, free;
  logic signed [33:0]   hdiff;
  logic signed [32:0]   sig, hist;

  always_comb begin
    pk      = macd_pkg::clamp_period(period[cmd.k]);
    pk1     = {1'b0, pk} + 9'd1;
    acc_k   = acc[cmd.k];
    macd    = 33'(acc[0] - acc[1]);
    mv      = vld[0] & vld[1];
    x       = (cmd.k == macd_pkg::EMA_SIGNAL) ? macd_pkg::ACC_W'(macd)
                                              : macd_pkg::ACC_W'({1'b0, price_q});
    present = (cmd.k == macd_pkg::EMA_SIGNAL) ? mv : !missing_q;
    sum     = (started[cmd.k] ? acc_k : '0) + x;
    cnt1    = (started[cmd.k] ? cnt[cmd.k] : 8'd0) + 8'd1;
    sum_mag = sum[macd_pkg::ACC_W-1] ? -sum : sum;

    status.ev = macd_pkg::EV_NONE;
    if (pk != 8'd0 && !dead[cmd.k] && present) begin
      if (!seeded[cmd.k]) begin
        if (cnt1 >= pk) begin
          status.ev = macd_pkg::EV_SEED;
        end
      end else if (alpha_ok[cmd.k]) begin
        status.ev = macd_pkg::EV_MUL;
      end else begin
        status.ev = macd_pkg::EV_ALPHA;
      end
    end

    if (cmd.div_alpha) begin
      div_num = macd_pkg::DIV_W'(64'd1 << (macd_pkg::ALPHA_FRAC + 1))
              + macd_pkg::DIV_W'(pk1 >> 1);
      div_den = pk1;
    end else begin
      div_num = sum_mag[macd_pkg::DIV_W-1:0] + macd_pkg::DIV_W'(cnt1 >> 1);
      div_den = {1'b0, cnt1};
    end

    d     = x - acc_k;
    d_mag = d[macd_pkg::ACC_W-1] ? -d : d;
    r     = macd_pkg::ACC_W'((prod + (64'd1 << (macd_pkg::ALPHA_FRAC - 1)))
                             >> macd_pkg::ALPHA_FRAC);

    gv    = vld[2] & mv;
    sig   = acc[2][32:0];
    hdiff = 34'(macd) - 34'(sig);
    if (hdiff > 34'sh0FFFFFFFF) begin
      hist = 33'sh0FFFFFFFF;
    end else if (hdiff < -34'sh100000000) begin
      hist = 33'sh100000000;
    end else begin
      hist = hdiff[32:0];
    end

    free            = !out_valid || out_ready;
    status.out_free = free;
    status.div_busy = div_busy;
  end

  macd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_go),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      period[0] <= 8'd12;
      period[1] <= 8'd26;
      period[2] <= 8'd9;
      acc[0]    <= '0;
      acc[1]    <= '0;
      acc[2]    <= '0;
      cnt[0]    <= '0;
      cnt[1]    <= '0;
      cnt[2]    <= '0;
      started   <= '0;
      seeded    <= '0;
      dead      <= '0;
      alpha_ok  <= '0;
      vld       <= '0;
      prev_macd <= '0;
      prev_sig  <= '0;
      prev_bv   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        alpha_ok <= '0;
        case (cfg_index)
          macd_pkg::REG_FAST:   period[0] <= cfg_data;
          macd_pkg::REG_SLOW:   period[1] <= cfg_data;
          macd_pkg::REG_SIGNAL: period[2] <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.latch_in) begin
        vld <= '0;
      end
      if (cmd.eval_commit && pk != 8'd0 && !dead[cmd.k]) begin
        if (!present) begin
          if (started[cmd.k]) begin
            dead[cmd.k] <= 1'b1;
          end
        end else if (!seeded[cmd.k]) begin
          acc[cmd.k]     <= sum;
          cnt[cmd.k]     <= cnt1;
          started[cmd.k] <= 1'b1;
        end
      end
      if (cmd.seed_write) begin
        acc[cmd.k]    <= seed_neg ? -macd_pkg::ACC_W'(quo) : macd_pkg::ACC_W'(quo);
        seeded[cmd.k] <= 1'b1;
        vld[cmd.k]    <= 1'b1;
      end
      if (cmd.alpha_write) begin
        alpha_ok[cmd.k] <= 1'b1;
      end
      if (cmd.upd_write) begin
        acc[cmd.k] <= d_neg ? acc_k - r : acc_k + r;
        vld[cmd.k] <= 1'b1;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        prev_bv   <= gv;
        prev_macd <= gv ? macd : '0;
        prev_sig  <= gv ? sig : '0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      price_q   <= price;
      missing_q <= price_missing;
    end
    if (cmd.div_go) begin
      seed_neg <= sum[macd_pkg::ACC_W-1];
    end
    if (cmd.alpha_write) begin
      alpha[cmd.k] <= quo[31:0];
    end
    if (cmd.mul_load) begin
      prod  <= {30'd0, d_mag[33:0]} * {32'd0, alpha[cmd.k]};
      d_neg <= d[macd_pkg::ACC_W-1];
    end
    if (cmd.finish) begin
      macd_valid   <= mv;
      macd_value   <= mv ? macd : '0;
      signal_valid <= gv;
      signal_line  <= gv ? sig : '0;
      histogram    <= gv ? hist : '0;
      cross_up     <= gv && prev_bv && macd > sig && prev_macd <= prev_sig;
      cross_down   <= gv && prev_bv && macd < sig && prev_macd >= prev_sig;
    end
  end

endmodule

// File: design/macd_ctrl.sv
// Walks fast, slow, then signal EMA for each sample.
module macd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  macd_pkg::status_t status,
  output macd_pkg::cmd_t    cmd
);

  macd_pkg::state_t state, state_next;
  logic [1:0]       k, k_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= macd_pkg::ST_IDLE;
      k     <= macd_pkg::EMA_FAST;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    cmd        = '0;
    cmd.k      = k;
    in_ready   = 1'b0;
    case (state)
      macd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          k_next       = macd_pkg::EMA_FAST;
          state_next   = macd_pkg::ST_EVAL;
        end
      end
      macd_pkg::ST_EVAL: begin
        cmd.eval_commit = 1'b1;
        case (status.ev)
          macd_pkg::EV_SEED: begin
            cmd.div_go = 1'b1;
            state_next = macd_pkg::ST_SEED;
          end
          macd_pkg::EV_ALPHA: begin
            cmd.div_go    = 1'b1;
            cmd.div_alpha = 1'b1;
            state_next    = macd_pkg::ST_ALPHA;
          end
          macd_pkg::EV_MUL: state_next = macd_pkg::ST_MUL;
          default:          state_next = macd_pkg::ST_NEXT;
        endcase
      end
      macd_pkg::ST_SEED: begin
        if (!status.div_busy) begin
          cmd.seed_write = 1'b1;
          state_next     = macd_pkg::ST_NEXT;
        end
      end
      macd_pkg::ST_ALPHA: begin
        if (!status.div_busy) begin
          cmd.alpha_write = 1'b1;
          state_next      = macd_pkg::ST_MUL;
        end
      end
      macd_pkg::ST_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = macd_pkg::ST_UPD;
      end
      macd_pkg::ST_UPD: begin
        cmd.upd_write = 1'b1;
        state_next    = macd_pkg::ST_NEXT;
      end
      macd_pkg::ST_NEXT: begin
        if (k == macd_pkg::EMA_SIGNAL) begin
          state_next = macd_pkg::ST_DONE;
        end else begin
          k_next     = k + 2'd1;
          state_next = macd_pkg::ST_EVAL;
        end
      end
      macd_pkg::ST_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = macd_pkg::ST_IDLE;
        end
      end
      default: state_next = macd_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: design/macd_crossover_indicator.sv
// channel   dir  payload
// samples   in   price[31:0], price_missing
// results   out  macd_valid, macd_value, signal_valid, signal_line, histogram,
//                cross_up, cross_down
// cfg       in   index[1:0] (0 fast, 1 slow, 2 signal period), data[7:0]
//
// One sample at a time. An EMA with no value is only evaluated; otherwise it gets a
// multiply-add update, its seed mean goes through the shared 42-step divider, or a
// new alpha is divided out before the update. The sequencer also has states for
// accepting the sample and loading the result.
// Alphas are recomputed once after reset and after each config write.
// Synchronous reset restores the default periods and clears all EMA state.
// A stalled result register holds the sequencer in its last state; cfg is always ready.
module macd_crossover_indicator (
  input logic         clk,
  input logic         rst,
  macd_in_if.sink     samples,
  macd_out_if.source  results,
  macd_cfg_if.sink    cfg
);

  macd_pkg::cmd_t    cmd;
  macd_pkg::status_t status;

  assign cfg.ready = 1'b1;

  macd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .status   (status),
    .cmd      (cmd)
  );

  macd_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .price         (samples.price),
    .price_missing (samples.price_missing),
    .cfg_we        (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .out_ready     (results.ready),
    .out_valid     (results.valid),
    .macd_valid    (results.macd_valid),
    .macd_value    (results.macd_value),
    .signal_valid  (results.signal_valid),
    .signal_line   (results.signal_line),
    .histogram     (results.histogram),
    .cross_up      (results.cross_up),
    .cross_down    (results.cross_down)
  );

endmodule

// File: tb/sv/macd_checker.sv
`default_nettype none

module macd_checker (
  input  logic clk,
  input  logic rst,
  macd_in_if   samples,
  macd_out_if  results,
  macd_cfg_if  cfg,
  output int   fail_count,
  output int   pending,
  output int   result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        macd_valid;
    logic [32:0] macd_value;
    logic        signal_valid;
    logic [32:0] signal_line;
    logic [32:0] histogram;
    logic        cross_up;
    logic        cross_down;
  } indicator_t;

  localparam longint SAT_HI = 64'sd4294967295;
  localparam longint SAT_LO = -64'sd4294967296;

  indicator_t indicator_q[$];

  logic [7:0] period_reg[3];
  longint     ema_acc[3];
  int         seed_cnt[3];
  bit         started[3];
  bit         seeded[3];
  bit         dead[3];
  longint     prev_macd;
  longint     prev_sig;
  bit         prev_both;

  // one EMA stage; returns 1 when the EMA holds a value after this input
  function automatic bit ema_advance(int k, bit present, longint x, output longint val);
    longint unsigned alpha, mag, r, den, cnt;
    longint          d;
    int              p;
    val = 0;
    p = int'(macd_pkg::clamp_period(period_reg[k]));
    if (p == 0 || dead[k]) return 0;
    if (!present) begin
      if (started[k]) dead[k] = 1;
      return 0;
    end
    if (!started[k]) begin
      started[k] = 1;
      ema_acc[k] = 0;
      seed_cnt[k] = 0;
    end
    if (!seeded[k]) begin
      ema_acc[k] += x;
      seed_cnt[k]++;
      if (seed_cnt[k] < p) return 0;
      cnt = longint'(seed_cnt[k]);
      mag = ema_acc[k] < 0 ? longint'(-ema_acc[k]) : longint'(ema_acc[k]);
      mag = (mag + cnt / 2) / cnt;
      ema_acc[k] = ema_acc[k] < 0 ? -longint'(mag) : longint'(mag);
      seeded[k] = 1;
    end else begin
      den = longint'(p) + 1;
      alpha = ((64'd1 << 31) + den / 2) / den;
      d = x - ema_acc[k];
      mag = d < 0 ? longint'(-d) : longint'(d);
      r = (mag * alpha + (64'd1 << 29)) >> macd_pkg::ALPHA_FRAC;
      ema_acc[k] += d < 0 ? -longint'(r) : longint'(r);
    end
    val = ema_acc[k];
    return 1;
  endfunction

  function automatic indicator_t predict_indicator(logic [31:0] price, logic missing);
    indicator_t e;
    longint     fast, slow, macd, sig, hist;
    bit         fv, sv, mv, gv, up, down;
    macd = 0;
    hist = 0;
    up = 0;
    down = 0;
    fv = ema_advance(macd_pkg::EMA_FAST, !missing, longint'({32'd0, price}), fast);
    sv = ema_advance(macd_pkg::EMA_SLOW, !missing, longint'({32'd0, price}), slow);
    mv = fv && sv;
    if (mv) macd = fast - slow;
    gv = ema_advance(macd_pkg::EMA_SIGNAL, mv, macd, sig) && mv;
    if (!gv) sig = 0;
    if (gv) begin
      hist = macd - sig;
      if (hist > SAT_HI) hist = SAT_HI;
      if (hist < SAT_LO) hist = SAT_LO;
      if (prev_both) begin
        up = macd > sig && prev_macd <= prev_sig;
        down = macd < sig && prev_macd >= prev_sig;
      end
    end
    prev_both = gv;
    prev_macd = gv ? macd : 0;
    prev_sig = gv ? sig : 0;
    e.macd_valid = mv;
    e.macd_value = macd[32:0];
    e.signal_valid = gv;
    e.signal_line = sig[32:0];
    e.histogram = hist[32:0];
    e.cross_up = up;
    e.cross_down = down;
    return e;
  endfunction

  assign pending = indicator_q.size();

  always @(posedge clk) begin
    indicator_t exp_r, got;
    if (rst) begin
      indicator_q.delete();
      period_reg[macd_pkg::EMA_FAST] = 8'd12;
      period_reg[macd_pkg::EMA_SLOW] = 8'd26;
      period_reg[macd_pkg::EMA_SIGNAL] = 8'd9;
      for (int k = 0; k < 3; k++) begin
        ema_acc[k] = 0;
        seed_cnt[k] = 0;
        started[k] = 0;
        seeded[k] = 0;
        dead[k] = 0;
      end
      prev_macd = 0;
      prev_sig = 0;
      prev_both = 0;
      fail_count = 0;
      result_count = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          macd_pkg::REG_FAST:   period_reg[macd_pkg::EMA_FAST] = cfg.data;
          macd_pkg::REG_SLOW:   period_reg[macd_pkg::EMA_SLOW] = cfg.data;
          macd_pkg::REG_SIGNAL: period_reg[macd_pkg::EMA_SIGNAL] = cfg.data;
          default: ;
        endcase
      end
      if (samples.valid && samples.ready)
        indicator_q.push_back(predict_indicator(samples.price, samples.price_missing));
      if (results.valid && results.ready) begin
        result_count++;
        got = {results.macd_valid, results.macd_value, results.signal_valid,
               results.signal_line, results.histogram, results.cross_up, results.cross_down};
        if (indicator_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("[%0t] result transfer with nothing expected", $time);
        end else begin
          exp_r = indicator_q.pop_front();
          if (got !== exp_r) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"[%0t] result %0d mismatch\n  exp mv=%b macd=%h sv=%b sig=%h ",
                        "hist=%h up=%b dn=%b\n  got mv=%b macd=%h sv=%b sig=%h hist=%h ",
                        "up=%b dn=%b"}, $time, result_count,
                       exp_r.macd_valid, exp_r.macd_value, exp_r.signal_valid,
                       exp_r.signal_line, exp_r.histogram, exp_r.cross_up, exp_r.cross_down,
                       got.macd_valid, got.macd_value, got.signal_valid, got.signal_line,
                       got.histogram, got.cross_up, got.cross_down);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/tb_macd_crossover_indicator.sv
`default_nettype none

module tb_macd_crossover_indicator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 200;

  logic clk;
  logic rst;
  int   fail_count, pending, result_count;
  int   idle_cycles;
  int   sent;
  bit   tx_bursty, rx_bursty;
  bit   hold_request;
  int   hold_cycles, stall_run;
  int   missing_sent;
  longint walk;

  macd_in_if  samples ();
  macd_out_if results ();
  macd_cfg_if cfg ();

  macd_crossover_indicator dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results),
    .cfg     (cfg)
  );

  macd_checker chk (
    .clk          (clk),
    .rst          (rst),
    .samples      (samples),
    .results      (results),
    .cfg          (cfg),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(120, 30);
  endfunction

  // mostly a random walk so crossings happen; sometimes full-range jumps
  function automatic logic [31:0] next_price();
    int r;
    r = $urandom_range(99);
    if (r < 80) begin
      walk += longint'($urandom_range(8192)) - 4096;
      if (walk < 0) walk = 0;
      if (walk > 64'hFFFF_FFFF) walk = 64'hFFFF_FFFF;
      return walk[31:0];
    end
    if (r < 90) return $urandom;
    if (r < 95) return 32'd0;
    return 32'hFFFF_FFFF;
  endfunction

  // entered and left at a falling edge
  task automatic send_sample(input logic [31:0] price, input logic missing);
    int gap;
    gap = tx_bursty ? pick_gap() : 0;
    if (gap > 0) begin
      samples.valid = 0;
      repeat (gap) @(negedge clk);
    end
    samples.valid = 1;
    samples.price = price;
    samples.price_missing = missing;
    do @(posedge clk); while (!samples.ready);
    @(negedge clk);
    sent++;
    if (sent % 97 == 0) tx_bursty = !tx_bursty;
    if (sent % 131 == 0) rx_bursty = !rx_bursty;
  endtask

  task automatic write_period(input logic [1:0] index, input logic [7:0] value);
    cfg.valid = 1;
    cfg.index = index;
    cfg.data = value;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 0;
  endtask

  // drain, let the sequencer finish, then load all three periods
  task automatic set_periods(input logic [7:0] f, input logic [7:0] s, input logic [7:0] g);
    samples.valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_period(macd_pkg::REG_FAST, f);
    write_period(macd_pkg::REG_SLOW, s);
    write_period(macd_pkg::REG_SIGNAL, g);
  endtask

  task automatic run_random(input int count, input int missing_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < missing_pct) begin
        missing_sent++;
        send_sample($urandom, 1'b1);
      end else begin
        send_sample(next_price(), 1'b0);
      end
    end
  endtask

  // receiver
  initial begin
    results.ready = 0;
    hold_cycles = 0;
    stall_run = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_cycles = 400;
        hold_request = 0;
      end
      if (hold_cycles > 0) begin
        results.ready = 0;
        hold_cycles--;
      end else if (stall_run > 0) begin
        results.ready = 0;
        stall_run--;
      end else begin
        results.ready = 1;
        if (rx_bursty && $urandom_range(99) < 30) stall_run = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (samples.valid && samples.ready) || (results.valid && results.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d results pending",
                 IDLE_LIMIT, pending);
        $display("tb_macd_crossover_indicator: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst = 1;
    samples.valid = 0;
    samples.price = 0;
    samples.price_missing = 0;
    cfg.valid = 0;
    cfg.index = macd_pkg::REG_FAST;
    cfg.data = 0;
    sent = 0;
    missing_sent = 0;
    tx_bursty = 0;
    rx_bursty = 0;
    hold_request = 0;
    walk = 64'h0064_0000;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // leading missing samples are skipped, then price extremes on default periods
    repeat (4) send_sample($urandom, 1'b1);
    send_sample(32'd0, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'd1, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'd0, 1'b0);
    for (int i = 0; i < 13; i++) send_sample(next_price(), 1'b0);

    // slow EMA still seeding here: period drops below its count
    set_periods(8'd1, 8'd1, 8'd1);
    run_random(60, 0);
    set_periods(8'd3, 8'd5, 8'd2);
    tx_bursty = 1;
    rx_bursty = 1;
    run_random(150, 0);
    hold_request = 1;
    run_random(150, 0);
    set_periods(8'd2, 8'd255, 8'd1);
    run_random(350, 0);
    set_periods(8'd1, 8'd255, 8'd255);
    run_random(300, 0);
    set_periods(8'd12, 8'd26, 8'd9);
    run_random(250, 0);
    set_periods(8'd7, 8'd3, 8'd4);
    run_random(200, 0);
    // zero fast period invalidates MACD, which kills the signal EMA
    set_periods(8'd0, 8'd26, 8'd9);
    run_random(60, 0);
    set_periods(8'd5, 8'd26, 8'd9);
    run_random(80, 0);
    // missing samples after start kill the price EMAs
    run_random(250, 10);

    samples.valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d samples (%0d missing) and %0d results over 9 period settings,",
             sent, missing_sent, result_count);
    $display("including seeding, zero periods, extreme prices and long output stalls");
    if (fail_count == 0 && pending == 0) begin
      $display("tb_macd_crossover_indicator: PASS");
    end else begin
      $display("%0d mismatches, %0d results never seen", fail_count, pending);
      $display("tb_macd_crossover_indicator: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
